// File: hw/rtl/dpst_pkg.sv
// shared types and codes for the dirty page set tracker
package dpst_pkg;

    localparam int PAGE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_CHANGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FLUSHED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_FLAG,
        S_LAST,
        S_SCAN,
        S_FRD,
        S_FEM
    } state_t;

endpackage

// File: hw/rtl/dirty_page_set_tracker.sv
// dirty page set tracker: flag memory plus dense page list with swap removal
//
// input channel s_*: one word per operation, tuser carries the operation
// (mark, clear, flush, or the unused code which only reports), tdata the page.
// result channel m_*: one word per result, tlast on the final result of an
// operation. mark and clear give one result, flush one per listed page, or a
// single flush-empty result when nothing is dirty.
// the memories have registered reads. out of range, unused code and empty
// flush give their result without reading the memories; mark first reads
// the flag of the page; clear reads the flag and, for a dirty page, scans
// the list linearly from the head for the page; flush emits a result per
// listed page.
// a new word is taken only once the previous operation is finished.
// after reset the flag memory is wiped entry by entry, during which
// s_tready stays low. the result sits in an output register; when the
// receiver stalls it holds, and a flush pauses until the word is taken.
module dirty_page_set_tracker #(
    parameter int PAGES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] page_id
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] page_id_out, [22:16] dirty_count, [23] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);

    localparam int PW = $clog2(PAGES);
    localparam int CW = $clog2(PAGES + 1);

    // memories
    logic flag_mem [PAGES];
    logic [PW-1:0] list_mem [PAGES];

    logic          flag_we;
    logic [PW-1:0] flag_waddr;
    logic          flag_wdata;
    logic [PW-1:0] flag_raddr;
    logic          flag_rd_reg;

    logic          list_we;
    logic [PW-1:0] list_waddr;
    logic [PW-1:0] list_wdata;
    logic [PW-1:0] list_raddr;
    logic [PW-1:0] list_rd_reg;

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        flag_rd_reg <= flag_mem[flag_raddr];
    end

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rd_reg <= list_mem[list_raddr];
    end

    // control and payload registers
    dpst_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [1:0]    op_reg, op_next;
    logic [15:0]   page_reg, page_next;
    logic [PW-1:0] last_val_reg, last_val_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_page_reg, out_page_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic          out_last_reg, out_last_next;
    logic [6:0]    out_count_reg, out_count_next;

    logic          out_free;
    logic          accept;
    logic          emit;
    logic          in_range;
    logic [CW-1:0] idx_plus1;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == dpst_pkg::S_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign in_range   = s_tdata < 16'(PAGES);
    assign idx_plus1  = CW'(idx_reg) + CW'(1);
    assign flag_raddr = s_tdata[PW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dpst_pkg::S_WIPE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        page_reg       <= page_next;
        last_val_reg   <= last_val_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_count_reg  <= out_count_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        last_val_next   = last_val_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_count_next  = out_count_reg;
        emit            = 1'b0;
        flag_we         = 1'b0;
        flag_waddr      = page_reg[PW-1:0];
        flag_wdata      = 1'b0;
        list_we         = 1'b0;
        list_waddr      = count_reg[PW-1:0];
        list_wdata      = page_reg[PW-1:0];
        list_raddr      = idx_reg;

        case (state_reg)
            dpst_pkg::S_WIPE: begin
                flag_we    = 1'b1;
                flag_waddr = idx_reg;
                if (idx_reg == PW'(PAGES - 1)) begin
                    idx_next   = '0;
                    state_next = dpst_pkg::S_IDLE;
                end else begin
                    idx_next = idx_reg + PW'(1);
                end
            end

            dpst_pkg::S_IDLE: begin
                if (accept) begin
                    op_next   = s_tuser;
                    page_next = s_tdata;
                    idx_next  = '0;
                    out_page_next  = s_tdata;
                    out_last_next  = 1'b1;
                    out_count_next = 7'(count_reg);
                    if (s_tuser == dpst_pkg::OP_FLUSH) begin
                        if (count_reg == '0) begin
                            emit            = 1'b1;
                            out_page_next   = '0;
                            out_status_next = dpst_pkg::ST_EMPTY;
                        end else begin
                            state_next = dpst_pkg::S_FRD;
                        end
                    end else if (s_tuser == dpst_pkg::OP_NONE) begin
                        emit            = 1'b1;
                        out_status_next = dpst_pkg::ST_NOCHANGE;
                    end else if (!in_range) begin
                        emit            = 1'b1;
                        out_status_next = dpst_pkg::ST_RANGE;
                    end else begin
                        state_next = dpst_pkg::S_FLAG;
                    end
                end
            end

            dpst_pkg::S_FLAG: begin
                // flag_rd_reg holds the flag of page_reg
                if (op_reg == dpst_pkg::OP_MARK) begin
                    emit       = 1'b1;
                    state_next = dpst_pkg::S_IDLE;
                    if (flag_rd_reg || count_reg >= CW'(PAGES)) begin
                        out_status_next = dpst_pkg::ST_NOCHANGE;
                    end else begin
                        flag_we         = 1'b1;
                        flag_wdata      = 1'b1;
                        list_we         = 1'b1;
                        count_next      = count_reg + CW'(1);
                        out_status_next = dpst_pkg::ST_CHANGED;
                        out_count_next  = 7'(count_reg + CW'(1));
                    end
                end else if (!flag_rd_reg) begin
                    emit            = 1'b1;
                    out_status_next = dpst_pkg::ST_NOCHANGE;
                    state_next      = dpst_pkg::S_IDLE;
                end else begin
                    flag_we    = 1'b1;
                    list_raddr = PW'(count_reg - CW'(1));
                    state_next = dpst_pkg::S_LAST;
                end
            end

            dpst_pkg::S_LAST: begin
                last_val_next = list_rd_reg;
                list_raddr    = '0;
                idx_next      = '0;
                state_next    = dpst_pkg::S_SCAN;
            end

            dpst_pkg::S_SCAN: begin
                // list_rd_reg holds list entry idx_reg
                if (list_rd_reg == page_reg[PW-1:0] && CW'(idx_reg) < count_reg) begin
                    list_we         = 1'b1;
                    list_waddr      = idx_reg;
                    list_wdata      = last_val_reg;
                    count_next      = count_reg - CW'(1);
                    emit            = 1'b1;
                    out_status_next = dpst_pkg::ST_CHANGED;
                    out_count_next  = 7'(count_reg - CW'(1));
                    state_next      = dpst_pkg::S_IDLE;
                end else if (idx_plus1 >= count_reg || idx_reg == PW'(PAGES - 1)) begin
                    // flag set but page not listed: flag already dropped
                    emit            = 1'b1;
                    out_status_next = dpst_pkg::ST_CHANGED;
                    state_next      = dpst_pkg::S_IDLE;
                end else begin
                    idx_next   = idx_reg + PW'(1);
                    list_raddr = idx_reg + PW'(1);
                end
            end

            dpst_pkg::S_FRD: begin
                list_raddr = idx_reg;
                state_next = dpst_pkg::S_FEM;
            end

            dpst_pkg::S_FEM: begin
                list_raddr = idx_reg;
                if (out_free) begin
                    emit            = 1'b1;
                    flag_we         = 1'b1;
                    flag_waddr      = list_rd_reg;
                    out_page_next   = 16'(list_rd_reg);
                    out_status_next = dpst_pkg::ST_FLUSHED;
                    out_count_next  = 7'(count_reg - idx_plus1);
                    if (idx_plus1 >= count_reg) begin
                        out_last_next = 1'b1;
                        count_next    = '0;
                        state_next    = dpst_pkg::S_IDLE;
                    end else begin
                        out_last_next = 1'b0;
                        idx_next      = idx_reg + PW'(1);
                        state_next    = dpst_pkg::S_FRD;
                    end
                end
            end

            default: begin
                state_next = dpst_pkg::S_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_page_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: bench/dpst_checker.sv
`timescale 1ns / 100ps
// result predictor and comparator for the dirty page set tracker channels
module dpst_checker #(
    parameter int PAGES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] page_id
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] page_id_out, [22:16] dirty_count, [23] zero
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        m_tlast,
    output int          error_count,
    output int          results_pending
);

    typedef struct packed {
        logic [dpst_pkg::PAGE_W-1:0]   page_id;
        logic [dpst_pkg::STATUS_W-1:0] status;
        logic                          last;
        logic [dpst_pkg::COUNT_W-1:0]  dirty_count;
    } page_result_t;

    logic [PAGES-1:0]            dirty_flags;
    logic [dpst_pkg::PAGE_W-1:0] dirty_list [PAGES];
    int                          list_len;
    page_result_t                page_results [$];

    // appends one expected result word to the tail of the queue
    function automatic void expect_word(input logic [dpst_pkg::PAGE_W-1:0] page,
                                        input logic [dpst_pkg::STATUS_W-1:0] status,
                                        input logic last, input int count);
        page_result_t r;
        r.page_id     = page;
        r.status      = status;
        r.last        = last;
        r.dirty_count = count[dpst_pkg::COUNT_W-1:0];
        page_results.insert(page_results.size(), r);
    endfunction

    // updates the dirty set for one operation and queues the words it produces
    function automatic void apply_page_op(input logic [dpst_pkg::OP_W-1:0] op,
                                          input logic [dpst_pkg::PAGE_W-1:0] page);
        int n;
        if (op == dpst_pkg::OP_FLUSH) begin
            n = list_len;
            if (n == 0) begin
                expect_word('0, dpst_pkg::ST_EMPTY, 1'b1, 0);
            end else begin
                for (int i = 0; i < n; i++) begin
                    dirty_flags[dirty_list[i]] = 1'b0;
                    expect_word(dirty_list[i], dpst_pkg::ST_FLUSHED, i == n - 1, n - 1 - i);
                end
                list_len = 0;
            end
        end else if (op == dpst_pkg::OP_NONE) begin
            expect_word(page, dpst_pkg::ST_NOCHANGE, 1'b1, list_len);
        end else if (page >= PAGES) begin
            expect_word(page, dpst_pkg::ST_RANGE, 1'b1, list_len);
        end else if (op == dpst_pkg::OP_MARK) begin
            if (dirty_flags[page] || list_len >= PAGES) begin
                expect_word(page, dpst_pkg::ST_NOCHANGE, 1'b1, list_len);
            end else begin
                dirty_flags[page] = 1'b1;
                dirty_list[list_len] = page;
                list_len++;
                expect_word(page, dpst_pkg::ST_CHANGED, 1'b1, list_len);
            end
        end else begin
            if (!dirty_flags[page]) begin
                expect_word(page, dpst_pkg::ST_NOCHANGE, 1'b1, list_len);
            end else begin
                dirty_flags[page] = 1'b0;
                // swap removal: the tail entry moves into the freed slot
                for (int i = 0; i < list_len; i++) begin
                    if (dirty_list[i] == page) begin
                        dirty_list[i] = dirty_list[list_len - 1];
                        list_len--;
                        break;
                    end
                end
                expect_word(page, dpst_pkg::ST_CHANGED, 1'b1, list_len);
            end
        end
    endfunction

    function automatic void compare_result();
        page_result_t want;
        if (page_results.size() == 0) begin
            $error("unexpected result word: page_id_out %0d status %0d",
                   m_tdata[15:0], m_tuser);
            error_count++;
            return;
        end
        want = page_results.pop_front();
        if (m_tdata[15:0] !== want.page_id) begin
            $error("page_id_out: expected %0d, got %0d", want.page_id, m_tdata[15:0]);
            error_count++;
        end
        if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            error_count++;
        end
        if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            error_count++;
        end
        if (m_tdata[22:16] !== want.dirty_count) begin
            $error("dirty_count: expected %0d, got %0d", want.dirty_count, m_tdata[22:16]);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            dirty_flags = '0;
            list_len = 0;
            page_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                compare_result();
            end
            if (s_tvalid && s_tready) begin
                apply_page_op(s_tuser, s_tdata);
            end
        end
        results_pending <= page_results.size();
    end

endmodule

// File: bench/tb_dirty_page_set_tracker.sv
`timescale 1ns / 100ps
// stimulus and verdict for the dirty page set tracker
module tb_dirty_page_set_tracker;

    localparam int PAGES = 64;
    localparam int RANDOM_OPS = 36;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [15:0] page_id
    logic [1:0]  s_tuser = dpst_pkg::OP_MARK;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [15:0] page_id_out, [22:16] dirty_count, [23] zero
    logic [2:0]  m_tuser;         // [2:0] status
    logic        m_tlast;

    int error_count;
    int results_pending;
    int burst_left = 1;
    int stall_mode = 0;
    int stall_span = 0;

    dirty_page_set_tracker #(.PAGES(PAGES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    dpst_checker #(.PAGES(PAGES)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .error_count(error_count), .results_pending(results_pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver: switches between always ready, coin flip and long stalls
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(8, 40);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // one word on the input channel, then a gap when the burst runs out
    task automatic issue(input logic [1:0] op, input logic [15:0] page);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= page;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    initial begin
        int stride;
        int start;
        int pick;
        logic [15:0] hot_page;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        issue(dpst_pkg::OP_FLUSH, 16'h0000);        // nothing dirty yet
        issue(dpst_pkg::OP_MARK, 16'd0);
        issue(dpst_pkg::OP_MARK, 16'(PAGES - 1));
        issue(dpst_pkg::OP_MARK, 16'(PAGES));       // first page past the store
        issue(dpst_pkg::OP_MARK, 16'hFFFF);
        issue(dpst_pkg::OP_MARK, 16'd0);            // already dirty
        issue(dpst_pkg::OP_CLEAR, 16'd5);           // already clean
        issue(dpst_pkg::OP_CLEAR, 16'hFFFF);
        issue(dpst_pkg::OP_CLEAR, 16'(PAGES));
        issue(dpst_pkg::OP_NONE, 16'hAAAA);
        issue(dpst_pkg::OP_NONE, 16'h5555);
        issue(dpst_pkg::OP_MARK, 16'd10);
        issue(dpst_pkg::OP_MARK, 16'd20);
        issue(dpst_pkg::OP_MARK, 16'd30);
        issue(dpst_pkg::OP_CLEAR, 16'd0);           // head of list, tail swapped in
        issue(dpst_pkg::OP_CLEAR, 16'd30);          // head of list again, tail swapped in
        issue(dpst_pkg::OP_CLEAR, 16'd10);
        issue(dpst_pkg::OP_FLUSH, 16'hFFFF);        // page field is don't care on flush
        issue(dpst_pkg::OP_FLUSH, 16'h0000);
        drain();

        // fill every page in a scrambled order, then flush the full set
        stride = 2 * $urandom_range(0, PAGES / 2 - 1) + 1;
        start = $urandom_range(0, PAGES - 1);
        for (int k = 0; k < PAGES; k++) begin
            issue(dpst_pkg::OP_MARK, 16'((start + k * stride) % PAGES));
        end
        issue(dpst_pkg::OP_MARK, 16'(start));       // set full and page dirty
        issue(dpst_pkg::OP_FLUSH, 16'h0000);

        // random mix, mostly on a small hot set so marks and clears collide
        for (int n = 0; n < RANDOM_OPS; n++) begin
            pick = $urandom_range(0, 99);
            hot_page = 16'($urandom_range(0, 15));
            if (pick < 40) begin
                issue(dpst_pkg::OP_MARK, hot_page);
            end else if (pick < 68) begin
                issue(dpst_pkg::OP_CLEAR, hot_page);
            end else if (pick < 78) begin
                issue($urandom_range(0, 1) ? dpst_pkg::OP_MARK : dpst_pkg::OP_CLEAR,
                      16'($urandom_range(0, PAGES - 1)));
            end else if (pick < 86) begin
                issue(dpst_pkg::OP_FLUSH, 16'($urandom));
            end else if (pick < 94) begin
                issue($urandom_range(0, 1) ? dpst_pkg::OP_MARK : dpst_pkg::OP_CLEAR,
                      16'($urandom_range(PAGES, 16'hFFFF)));
            end else begin
                issue(dpst_pkg::OP_NONE, 16'($urandom));
            end
            if (n % 12 == 11) begin
                drain();
            end
        end

        drain();
        repeat (2 * PAGES + 8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_dirty_page_set_tracker: done, clean");
        end else begin
            $display("tb_dirty_page_set_tracker: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_dirty_page_set_tracker: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dpst_pkg.sv
hw/rtl/dirty_page_set_tracker.sv
bench/dpst_checker.sv
bench/tb_dirty_page_set_tracker.sv
